@@ rtl/fbpa_pkg.sv @@
// shared constants for the fixed block pool allocator
// status, command and register index codes, field widths and reset values
// no dependencies
`default_nettype none

package fbpa_pkg;

   // pool geometry default
   localparam int POOL_SLOTS_DEF = 64;

   // header word ahead of each block payload
   localparam int HEADER_BYTES = 4;

   // field widths fixed by the interface
   localparam int OFFSET_W  = 22;
   localparam int BLOCK_W   = 16;
   localparam int STRIDE_W  = 17;
   localparam int LIMIT_W   = 7;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   // command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_GRANTED      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL         = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FREED        = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVF_RELEASED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IGNORED      = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_SLOTS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES       = 1'd1;

   // register reset values
   localparam logic [LIMIT_W-1:0] RST_POOL_SLOTS_IN_USE = 7'd64;
   localparam logic [BLOCK_W-1:0] RST_BLOCK_BYTES       = 16'd64;

endpackage

`default_nettype wire

@@ rtl/fixed_block_pool_allocator.sv @@
// fixed block pool allocator top level: control sequencer and config registers
// depends on fbpa_pkg, fbpa_used_mem and fbpa_offset
//
// usage
//  - command channel: an item is taken at a rising edge with start high and
//    busy low; req_command selects allocate or free, req_slot_handle names
//    the slot to free (POOL_SLOTS is the overflow handle)
//  - result channel: one result per item, shown for exactly one cycle with
//    rsp_strobe high; the receiver cannot stall, so results never back up
//  - config channel: csr_ready is always high, a write lands at an edge with
//    csr_valid high; write only while busy is low and no result is pending
//  - result timing: overflow release and frees of handles past the pool show the
//    result the cycle after the item; a free of an unused slot passes S_FREE_CHK,
//    a free of a used slot S_FREE_CHK, S_MUL and S_EMIT; an allocate reads slots
//    from the hint upward, one read per cycle up to the limit (k reads, at most
//    POOL_SLOTS), then reports full, or when granted goes through S_MUL and S_EMIT
//  - busy falls in the cycle the result register is loaded, so the next item
//    can be taken while the result is on the ports
//  - reset: synchronous, active high; afterwards a clearing pass writes every
//    used bit to zero, one slot per cycle, with busy high
`default_nettype none

module fixed_block_pool_allocator #(
   parameter int POOL_SLOTS = fbpa_pkg::POOL_SLOTS_DEF,
   parameter int SLOT_W     = $clog2(POOL_SLOTS + 1)
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // command channel
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_command,
   input  wire logic [SLOT_W-1:0]                    req_slot_handle,
   // result channel
   output logic                                      rsp_strobe,
   output logic      [fbpa_pkg::STATUS_W-1:0]        rsp_status,
   output logic      [SLOT_W-1:0]                    rsp_slot_index,
   output logic      [fbpa_pkg::OFFSET_W-1:0]        rsp_byte_offset,
   // config channel
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [fbpa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [fbpa_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   // memory address width, at least one bit
   localparam int AW    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   // compare width for limit against pool size
   localparam int CMP_W = (SLOT_W > fbpa_pkg::LIMIT_W) ? SLOT_W : fbpa_pkg::LIMIT_W;

   localparam logic [SLOT_W-1:0] POOL_END  = SLOT_W'(POOL_SLOTS);
   localparam logic [SLOT_W-1:0] POOL_LAST = SLOT_W'(POOL_SLOTS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE_CHK,
      S_MUL,
      S_EMIT
   } state_type;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [fbpa_pkg::LIMIT_W-1:0] cfg_slots_ff;
   logic [fbpa_pkg::BLOCK_W-1:0] cfg_block_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_slots_ff <= fbpa_pkg::RST_POOL_SLOTS_IN_USE;
         cfg_block_ff <= fbpa_pkg::RST_BLOCK_BYTES;
      end else if (csr_valid) begin
         case (csr_index)
            fbpa_pkg::CSR_POOL_SLOTS_IN_USE: begin
               cfg_slots_ff <= csr_wdata[fbpa_pkg::LIMIT_W-1:0];
            end
            fbpa_pkg::CSR_BLOCK_BYTES: begin
               cfg_block_ff <= csr_wdata[fbpa_pkg::BLOCK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // active limit, clamped to the pool size
   logic [CMP_W-1:0]  lim_cmp;
   logic [CMP_W-1:0]  pool_cmp;
   logic [SLOT_W-1:0] limit;

   assign lim_cmp  = CMP_W'(cfg_slots_ff);
   assign pool_cmp = CMP_W'(POOL_SLOTS);
   assign limit    = (lim_cmp > pool_cmp) ? SLOT_W'(pool_cmp) : SLOT_W'(lim_cmp);

   // ---------------------------------------------------------------
   // used-bit memory and offset unit
   // ---------------------------------------------------------------
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic          mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic          mem_rd_data;

   fbpa_used_mem #(
      .DEPTH (POOL_SLOTS),
      .AW    (AW)
   ) u_used_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   logic [SLOT_W-1:0]             res_slot_ff;
   logic [SLOT_W-1:0]             res_slot_in;
   logic [fbpa_pkg::OFFSET_W-1:0] off_value;

   fbpa_offset #(
      .SLOT_W (SLOT_W)
   ) u_offset (
      .clock       (clock),
      .slot        (res_slot_ff),
      .block_bytes (cfg_block_ff),
      .byte_offset (off_value)
   );

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   state_type                     state_ff,  state_in;
   logic [SLOT_W-1:0]             rd_ptr_ff, rd_ptr_in;    // next slot to read, or clear ptr
   logic [SLOT_W-1:0]             chk_ptr_ff, chk_ptr_in;  // slot whose bit is on rd_data
   logic                          chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0]             hint_ff,   hint_in;
   logic [fbpa_pkg::STATUS_W-1:0] res_st_ff, res_st_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic [fbpa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]             rsp_slot_ff,   rsp_slot_in;
   logic [fbpa_pkg::OFFSET_W-1:0] rsp_off_ff,    rsp_off_in;

   always_comb begin
      state_in      = state_ff;
      rd_ptr_in     = rd_ptr_ff;
      chk_ptr_in    = chk_ptr_ff;
      chk_vld_in    = chk_vld_ff;
      hint_in       = hint_ff;
      res_slot_in   = res_slot_ff;
      res_st_in     = res_st_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_off_in    = rsp_off_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = chk_ptr_ff[AW-1:0];
      mem_wr_data   = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = rd_ptr_ff[AW-1:0];

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = rd_ptr_ff[AW-1:0];
            mem_wr_data = 1'b0;
            if (rd_ptr_ff == POOL_LAST) begin
               rd_ptr_in = '0;
               state_in  = S_IDLE;
            end else begin
               rd_ptr_in = SLOT_W'(rd_ptr_ff + 1'b1);
            end
         end

         S_IDLE: begin
            if (start) begin
               if (req_command == fbpa_pkg::CMD_ALLOC) begin
                  rd_ptr_in  = hint_ff;
                  chk_vld_in = 1'b0;
                  state_in   = S_SCAN;
               end else if (req_slot_handle == POOL_END) begin
                  // overflow block released outside the pool
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = fbpa_pkg::ST_OVF_RELEASED;
                  rsp_slot_in   = POOL_END;
                  rsp_off_in    = '0;
               end else if (req_slot_handle > POOL_END) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = fbpa_pkg::ST_IGNORED;
                  rsp_slot_in   = req_slot_handle;
                  rsp_off_in    = '0;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = req_slot_handle[AW-1:0];
                  chk_ptr_in  = req_slot_handle;
                  state_in    = S_FREE_CHK;
               end
            end
         end

         S_SCAN: begin
            // reads stream one slot per cycle; each check uses the registered read data
            if (chk_vld_ff && !mem_rd_data) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = chk_ptr_ff[AW-1:0];
               mem_wr_data = 1'b1;
               hint_in     = SLOT_W'(chk_ptr_ff + 1'b1);
               res_slot_in = chk_ptr_ff;
               res_st_in   = fbpa_pkg::ST_GRANTED;
               state_in    = S_MUL;
            end else if (rd_ptr_ff < limit) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_ptr_ff[AW-1:0];
               chk_ptr_in  = rd_ptr_ff;
               chk_vld_in  = 1'b1;
               rd_ptr_in   = SLOT_W'(rd_ptr_ff + 1'b1);
            end else begin
               // nothing free from the hint up to the limit, hint kept
               rsp_strobe_in = 1'b1;
               rsp_status_in = fbpa_pkg::ST_FULL;
               rsp_slot_in   = POOL_END;
               rsp_off_in    = '0;
               state_in      = S_IDLE;
            end
         end

         S_FREE_CHK: begin
            if (mem_rd_data) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = chk_ptr_ff[AW-1:0];
               mem_wr_data = 1'b0;
               if (hint_ff > chk_ptr_ff) begin
                  hint_in = chk_ptr_ff;
               end
               res_slot_in = chk_ptr_ff;
               res_st_in   = fbpa_pkg::ST_FREED;
               state_in    = S_MUL;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = fbpa_pkg::ST_IGNORED;
               rsp_slot_in   = chk_ptr_ff;
               rsp_off_in    = '0;
               state_in      = S_IDLE;
            end
         end

         S_MUL: begin
            // product registers inside the offset unit
            state_in = S_EMIT;
         end

         S_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = res_st_ff;
            rsp_slot_in   = res_slot_ff;
            rsp_off_in    = off_value;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         rd_ptr_ff     <= '0;
         chk_vld_ff    <= 1'b0;
         hint_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_ptr_ff     <= rd_ptr_in;
         chk_vld_ff    <= chk_vld_in;
         hint_ff       <= hint_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      chk_ptr_ff    <= chk_ptr_in;
      res_slot_ff   <= res_slot_in;
      res_st_ff     <= res_st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_off_ff    <= rsp_off_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_byte_offset = rsp_off_ff;

endmodule

`default_nettype wire

@@ rtl/fbpa_used_mem.sv @@
// used-bit memory: one bit per pool slot, one write and one read port
// read data registered; depends on nothing
`default_nettype none

module fbpa_used_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic          wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic               rd_data
);

   logic mem [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/fbpa_offset.sv @@
// payload byte offset unit: slot times stride, registered, plus header word
// depends on fbpa_pkg for widths and header size
`default_nettype none

module fbpa_offset #(
   parameter int SLOT_W = 7
) (
   input  wire logic                           clock,
   input  wire logic [SLOT_W-1:0]              slot,
   input  wire logic [fbpa_pkg::BLOCK_W-1:0]   block_bytes,
   output logic      [fbpa_pkg::OFFSET_W-1:0]  byte_offset
);

   localparam int PROD_W = SLOT_W + fbpa_pkg::STRIDE_W;
   localparam int EXT_W  = PROD_W + fbpa_pkg::OFFSET_W;

   logic [fbpa_pkg::STRIDE_W-1:0] stride;
   logic [PROD_W-1:0]             prod_ff;
   logic [PROD_W-1:0]             prod_in;
   logic [EXT_W-1:0]              sum;

   assign stride  = fbpa_pkg::STRIDE_W'(block_bytes)
                  + fbpa_pkg::STRIDE_W'(fbpa_pkg::HEADER_BYTES);
   assign prod_in = PROD_W'(slot) * PROD_W'(stride);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // offset wraps modulo the field width
   assign sum         = EXT_W'(prod_ff) + EXT_W'(fbpa_pkg::HEADER_BYTES);
   assign byte_offset = sum[fbpa_pkg::OFFSET_W-1:0];

endmodule

`default_nettype wire
